### rtl/ppfe_pkg.sv
package ppfe_pkg;

  localparam int MEAS_W  = 16;
  localparam int GAIN_W  = 32;
  localparam int LIMIT_W = 23;
  localparam int INTEG_W = 40;
  localparam int DRIVE_W = 32;
  localparam int CFG_W   = 32;

  typedef enum logic [1:0] {
    CFG_KP_GAIN        = 2'd0,
    CFG_KI_GAIN        = 2'd1,
    CFG_KD_GAIN        = 2'd2,
    CFG_INTEGRAL_LIMIT = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    CMD_STEP  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  localparam logic signed [GAIN_W-1:0]  KP_RESET    = 32'sd0;
  localparam logic signed [GAIN_W-1:0]  KI_RESET    = 32'sd1310720;
  localparam logic signed [GAIN_W-1:0]  KD_RESET    = 32'sd0;
  localparam logic        [LIMIT_W-1:0] LIMIT_RESET = 23'd4000;

endpackage

### rtl/positional_pid_filtered_error.sv
// Positional PID controller with a half-and-half low-pass on the error and a
// clamped integral.
// Input channel (in_valid / in_stall): each item carries a command, a measured
// value and a target. A step command updates the filtered error and integral;
// a clear command zeroes both and yields a zero drive.
// Result channel (out_valid / out_stall): exactly one result per input item,
// in order: the saturated drive and a flag telling that the integral was
// clamped or saturated on that step.
// Configuration: cfg_we writes cfg_wdata into the register cfg_idx selects
// (kp, ki, kd, integral limit); write only while the block holds no item.
// Items pass the input, filter, product, sum and result registers at
// one item per cycle while out_stall is low. The filter and integral update
// is a loop held in the second stage; the products and the final sum run in
// the following stages, with the 32x40 integral product split in two.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes the state and
// restores the register defaults.
// When the receiver stalls, the result holds on the ports; the pipeline keeps
// taking items until every stage is full, then raises in_stall.
module positional_pid_filtered_error #(
  parameter int ERROR_FRAC_BITS = 8,
  parameter int GAIN_FRAC_BITS  = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       cfg_we,
  input  logic [1:0]                                 cfg_idx,
  input  logic [ppfe_pkg::CFG_W-1:0]                 cfg_wdata,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic                                       in_command,
  input  logic signed [ppfe_pkg::MEAS_W-1:0]         in_measured,
  input  logic signed [ppfe_pkg::MEAS_W-1:0]         in_target,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic signed [ppfe_pkg::DRIVE_W-1:0]        out_drive,
  output logic                                       out_integral_clamped
);

  localparam int MW  = ppfe_pkg::MEAS_W;
  localparam int GW  = ppfe_pkg::GAIN_W;
  localparam int LW  = ppfe_pkg::LIMIT_W;
  localparam int IW  = ppfe_pkg::INTEG_W;
  localparam int OW  = ppfe_pkg::DRIVE_W;
  localparam int E   = ERROR_FRAC_BITS;
  localparam int FW  = MW + 2 + E;
  localparam int DW  = FW + 1;
  localparam int IL  = IW / 2;
  localparam int IH  = IW - IL;
  localparam int PKP_W = GW + FW;
  localparam int PKD_W = GW + DW;
  localparam int PLO_W = GW + IL + 1;
  localparam int PHI_W = GW + IH;
  localparam int AW  = GW + IW + 3;
  localparam int SH  = ERROR_FRAC_BITS + GAIN_FRAC_BITS;

  localparam logic signed [IW:0]   INT_MAX = {2'b00, {(IW-1){1'b1}}};
  localparam logic signed [IW:0]   INT_MIN = ~INT_MAX;
  localparam logic signed [AW-1:0] DRV_MAX = {{(AW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [AW-1:0] DRV_MIN = ~DRV_MAX;
  localparam logic signed [AW-1:0] RND     = AW'(1) << (SH - 1);

  // Configuration registers.
  logic signed [GW-1:0] kp_r, ki_r, kd_r;
  logic        [LW-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= ppfe_pkg::KP_RESET;
      ki_r    <= ppfe_pkg::KI_RESET;
      kd_r    <= ppfe_pkg::KD_RESET;
      limit_r <= ppfe_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (ppfe_pkg::cfg_idx_t'(cfg_idx))
        ppfe_pkg::CFG_KP_GAIN:        kp_r    <= cfg_wdata[GW-1:0];
        ppfe_pkg::CFG_KI_GAIN:        ki_r    <= cfg_wdata[GW-1:0];
        ppfe_pkg::CFG_KD_GAIN:        kd_r    <= cfg_wdata[GW-1:0];
        ppfe_pkg::CFG_INTEGRAL_LIMIT: limit_r <= cfg_wdata[LW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or its content moves on.
  logic v1_r, v2_r, v3_r, v4_r, ov_r;
  logic ld1, ld2, ld3, ld4, ld5;

  assign ld5 = !ov_r || !out_stall;
  assign ld4 = !v4_r || ld5;
  assign ld3 = !v3_r || ld4;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;
  assign in_stall = !ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
      if (ld5) ov_r <= v4_r;
    end
  end

  // Stage 1: input register.
  logic                 cmd_s1_r;
  logic signed [MW-1:0] meas_s1_r, tgt_s1_r;

  always_ff @(posedge clk) begin
    if (ld1 && in_valid) begin
      cmd_s1_r  <= in_command;
      meas_s1_r <= in_measured;
      tgt_s1_r  <= in_target;
    end
  end

  // Stage 2: filter and integral update, the only loop in the block.
  logic signed [FW-1:0] flt_last_r;
  logic signed [IW-1:0] integ_r;
  logic signed [FW-1:0] filt_s2_r;
  logic signed [IW-1:0] integ_s2_r;
  logic signed [DW-1:0] diff_s2_r;
  logic                 clamp_s2_r;

  logic signed [MW:0]   raw;
  logic signed [FW:0]   raw_fx, sum_fx;
  logic signed [FW-1:0] filt_nxt;
  logic signed [IW:0]   isum, lim, ival;
  logic signed [IW-1:0] integ_nxt;
  logic signed [DW-1:0] diff_nxt;
  logic                 clamp_nxt;

  always_comb begin
    raw      = {meas_s1_r[MW-1], meas_s1_r} - {tgt_s1_r[MW-1], tgt_s1_r};
    raw_fx   = {{(FW-MW-E){raw[MW]}}, raw, {E{1'b0}}};
    sum_fx   = raw_fx + {flt_last_r[FW-1], flt_last_r};
    filt_nxt = sum_fx[FW:1];
    isum     = {integ_r[IW-1], integ_r} + {{(IW+1-FW){filt_nxt[FW-1]}}, filt_nxt};
    lim      = {{(IW+1-LW-E){1'b0}}, limit_r, {E{1'b0}}};
    ival     = isum;
    clamp_nxt = 1'b0;
    if (limit_r != '0) begin
      if (isum > lim) begin
        ival = lim;
        clamp_nxt = 1'b1;
      end
      if (isum < -lim) begin
        ival = -lim;
        clamp_nxt = 1'b1;
      end
    end else begin
      if (isum > INT_MAX) begin
        ival = INT_MAX;
        clamp_nxt = 1'b1;
      end
      if (isum < INT_MIN) begin
        ival = INT_MIN;
        clamp_nxt = 1'b1;
      end
    end
    integ_nxt = ival[IW-1:0];
    diff_nxt  = {filt_nxt[FW-1], filt_nxt} - {flt_last_r[FW-1], flt_last_r};
    // A clear zeroes the state and every term, so the drive comes out as zero.
    if (ppfe_pkg::cmd_t'(cmd_s1_r) == ppfe_pkg::CMD_CLEAR) begin
      filt_nxt  = '0;
      integ_nxt = '0;
      diff_nxt  = '0;
      clamp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flt_last_r <= '0;
      integ_r    <= '0;
    end else if (ld2 && v1_r) begin
      flt_last_r <= filt_nxt;
      integ_r    <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2 && v1_r) begin
      filt_s2_r  <= filt_nxt;
      integ_s2_r <= integ_nxt;
      diff_s2_r  <= diff_nxt;
      clamp_s2_r <= clamp_nxt;
    end
  end

  // Stage 3: products. The integral product is split into a low unsigned half
  // and a high signed half.
  logic signed [PKP_W-1:0] pkp_s3_r;
  logic signed [PKD_W-1:0] pkd_s3_r;
  logic signed [PLO_W-1:0] plo_s3_r;
  logic signed [PHI_W-1:0] phi_s3_r;
  logic                    clamp_s3_r;

  always_ff @(posedge clk) begin
    if (ld3 && v2_r) begin
      pkp_s3_r   <= kp_r * filt_s2_r;
      pkd_s3_r   <= kd_r * diff_s2_r;
      plo_s3_r   <= ki_r * $signed({1'b0, integ_s2_r[IL-1:0]});
      phi_s3_r   <= ki_r * $signed(integ_s2_r[IW-1:IL]);
      clamp_s3_r <= clamp_s2_r;
    end
  end

  // Stage 4: exact sum of the terms.
  logic signed [AW-1:0] sum_nxt, sum_s4_r;
  logic                 clamp_s4_r;

  assign sum_nxt = AW'(pkp_s3_r) + AW'(pkd_s3_r) + AW'(plo_s3_r)
                 + (AW'(phi_s3_r) <<< IL);

  always_ff @(posedge clk) begin
    if (ld4 && v3_r) begin
      sum_s4_r   <= sum_nxt;
      clamp_s4_r <= clamp_s3_r;
    end
  end

  // Stage 5: round half up, scale down and saturate into the result register.
  logic signed [AW-1:0] scaled;
  logic signed [OW-1:0] drive_nxt;
  logic signed [OW-1:0] drive_r;
  logic                 clamp_r;

  always_comb begin
    scaled = (sum_s4_r + RND) >>> SH;
    if (scaled > DRV_MAX) begin
      drive_nxt = DRV_MAX[OW-1:0];
    end else if (scaled < DRV_MIN) begin
      drive_nxt = DRV_MIN[OW-1:0];
    end else begin
      drive_nxt = scaled[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld5 && v4_r) begin
      drive_r <= drive_nxt;
      clamp_r <= clamp_s4_r;
    end
  end

  assign out_valid            = ov_r;
  assign out_drive            = drive_r;
  assign out_integral_clamped = clamp_r;

  // A clear that moves into stage 2 leaves the state zeroed.
  a_clear_zeroes_state: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && ld2 && cmd_s1_r == ppfe_pkg::CMD_CLEAR) |=> (flt_last_r == '0 && integ_r == '0))
    else $error("state not zeroed after a clear item");

  // Input is held off only while the first stage holds an item that cannot move.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && ov_r && out_stall))
    else $error("input stalled with room in the pipeline");

  // A new result appears only when the last stage held an item.
  a_result_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(v4_r))
    else $error("result valid without an item in the last stage");

  // A taken result with nothing behind it empties the output.
  a_output_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_stall && !v4_r) |=> !ov_r)
    else $error("result repeated after it was taken");

endmodule

### verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ERR_FRAC  = 8;
  localparam int GAIN_FRAC = 16;
  localparam int OPEN_STEPS = 40;
  localparam int PHASE_ITEMS = 242;

  localparam logic signed [63:0]  INTEG_HI   =
    (64'sd1 <<< (ppfe_pkg::INTEG_W - 1)) - 64'sd1;
  localparam logic signed [63:0]  INTEG_LO   = -INTEG_HI - 64'sd1;
  localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (ERR_FRAC + GAIN_FRAC - 1);
  localparam logic signed [127:0] DRIVE_HI   = 128'sd2147483647;
  localparam logic signed [127:0] DRIVE_LO   = -DRIVE_HI - 128'sd1;

  typedef struct packed {
    logic signed [ppfe_pkg::DRIVE_W-1:0] drive;
    logic                                clamped;
  } pid_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [ppfe_pkg::CFG_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic in_command;
  logic signed [ppfe_pkg::MEAS_W-1:0] in_measured;
  logic signed [ppfe_pkg::MEAS_W-1:0] in_target;
  logic out_valid;
  logic out_stall;
  logic signed [ppfe_pkg::DRIVE_W-1:0] out_drive;
  logic out_integral_clamped;

  // Shadow copies of the registers and the controller state.
  logic signed [ppfe_pkg::GAIN_W-1:0] kp_q = ppfe_pkg::KP_RESET;
  logic signed [ppfe_pkg::GAIN_W-1:0] ki_q = ppfe_pkg::KI_RESET;
  logic signed [ppfe_pkg::GAIN_W-1:0] kd_q = ppfe_pkg::KD_RESET;
  logic [ppfe_pkg::LIMIT_W-1:0] limit_q = ppfe_pkg::LIMIT_RESET;
  logic signed [63:0] filt_err_q = '0;
  logic signed [63:0] integ_q = '0;

  pid_result_t pending_drives[$];
  int mismatch_count = 0;
  bit quiet = 1'b0;
  bit result_taken = 1'b0;
  int hold_left = 0;

  positional_pid_filtered_error #(
    .ERROR_FRAC_BITS(ERR_FRAC),
    .GAIN_FRAC_BITS (GAIN_FRAC)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_measured         (in_measured),
    .in_target           (in_target),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_drive           (out_drive),
    .out_integral_clamped(out_integral_clamped)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("positional_pid_filtered_error test failed");
    $finish;
  end

  // One control step: filter the error, update the integral and form the drive.
  function automatic pid_result_t pid_predict(input ppfe_pkg::cmd_t cmd,
                                              input logic signed [15:0] meas,
                                              input logic signed [15:0] tgt);
    logic signed [63:0] raw;
    logic signed [63:0] filt;
    logic signed [63:0] integ;
    logic signed [63:0] lim;
    logic signed [63:0] diff;
    logic signed [127:0] acc;
    pid_result_t res;
    res = '0;
    if (cmd == ppfe_pkg::CMD_CLEAR) begin
      filt_err_q = '0;
      integ_q = '0;
      return res;
    end
    raw = meas;
    raw = (raw - tgt) <<< ERR_FRAC;
    // An arithmetic shift of the sum is the floor of half of it.
    filt = (raw + filt_err_q) >>> 1;
    integ = integ_q + filt;
    if (limit_q != '0) begin
      lim = limit_q;
      lim = lim <<< ERR_FRAC;
      if (integ > lim) begin
        integ = lim;
        res.clamped = 1'b1;
      end
      if (integ < -lim) begin
        integ = -lim;
        res.clamped = 1'b1;
      end
    end else begin
      if (integ > INTEG_HI) begin
        integ = INTEG_HI;
        res.clamped = 1'b1;
      end
      if (integ < INTEG_LO) begin
        integ = INTEG_LO;
        res.clamped = 1'b1;
      end
    end
    diff = filt - filt_err_q;
    acc = kp_q * filt + ki_q * integ + kd_q * diff + ROUND_HALF;
    acc = acc >>> (ERR_FRAC + GAIN_FRAC);
    if (acc > DRIVE_HI) begin
      acc = DRIVE_HI;
    end else if (acc < DRIVE_LO) begin
      acc = DRIVE_LO;
    end
    res.drive = acc[ppfe_pkg::DRIVE_W-1:0];
    integ_q = integ;
    filt_err_q = filt;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      pending_drives.push_back(pid_predict(ppfe_pkg::cmd_t'(in_command), in_measured,
                                           in_target));
    end
  end

  always @(posedge clk) begin
    pid_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_taken = 1'b1;
      if (pending_drives.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result with no item pending: drive %0d clamped %0b",
                   $realtime, out_drive, out_integral_clamped);
        end
      end else begin
        want = pending_drives.pop_front();
        if (out_drive !== want.drive || out_integral_clamped !== want.clamped) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: mismatch: drive exp %0d got %0d, clamped exp %0b got %0b",
                     $realtime, want.drive, out_drive, want.clamped,
                     out_integral_clamped);
          end
        end
      end
    end
  end

  // After each item it takes, the receiver may stall at random, unless quiet is set.
  always @(negedge clk) begin
    if (result_taken) begin
      result_taken = 1'b0;
      hold_left = quiet ? 0 : $urandom_range(0, 3);
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  task automatic write_reg(input ppfe_pkg::cfg_idx_t idx,
                           input logic [ppfe_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = data;
    case (idx)
      ppfe_pkg::CFG_KP_GAIN: kp_q = data;
      ppfe_pkg::CFG_KI_GAIN: ki_q = data;
      ppfe_pkg::CFG_KD_GAIN: kd_q = data;
      ppfe_pkg::CFG_INTEGRAL_LIMIT: limit_q = data[ppfe_pkg::LIMIT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(input logic [ppfe_pkg::GAIN_W-1:0] kp,
                           input logic [ppfe_pkg::GAIN_W-1:0] ki,
                           input logic [ppfe_pkg::GAIN_W-1:0] kd,
                           input logic [ppfe_pkg::LIMIT_W-1:0] lim);
    write_reg(ppfe_pkg::CFG_KP_GAIN, kp);
    write_reg(ppfe_pkg::CFG_KI_GAIN, ki);
    write_reg(ppfe_pkg::CFG_KD_GAIN, kd);
    write_reg(ppfe_pkg::CFG_INTEGRAL_LIMIT, ppfe_pkg::CFG_W'(lim));
  endtask

  task automatic send_item(input ppfe_pkg::cmd_t cmd,
                           input logic signed [ppfe_pkg::MEAS_W-1:0] meas,
                           input logic signed [ppfe_pkg::MEAS_W-1:0] tgt);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_command = cmd;
    in_measured = meas;
    in_target = tgt;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every pending result has been checked.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_drives.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic signed [ppfe_pkg::MEAS_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return ppfe_pkg::MEAS_W'($urandom);
    endcase
  endfunction

  function automatic logic [ppfe_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return $urandom;
      default: return ppfe_pkg::GAIN_W'($signed(21'($urandom)));
    endcase
  endfunction

  function automatic logic [ppfe_pkg::LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 23'd1;
      2: return 23'h7F_FFFF;
      3: return ppfe_pkg::LIMIT_W'($urandom_range(1, 20000));
      default: return ppfe_pkg::LIMIT_W'($urandom);
    endcase
  endfunction

  task automatic run_default_gain_steps();
    send_item(ppfe_pkg::CMD_STEP, 16'sd0, 16'sd0);
    send_item(ppfe_pkg::CMD_STEP, 16'sh7FFF, 16'sh8000);
    send_item(ppfe_pkg::CMD_STEP, 16'sh7FFF, 16'sh8000);
    send_item(ppfe_pkg::CMD_STEP, 16'sh8000, 16'sh7FFF);
    send_item(ppfe_pkg::CMD_STEP, 16'sh8000, 16'sh7FFF);
    send_item(ppfe_pkg::CMD_STEP, -16'sd1, 16'sd0);
    send_item(ppfe_pkg::CMD_CLEAR, 16'sh7FFF, 16'sh8000);
    send_item(ppfe_pkg::CMD_STEP, 16'sd5, 16'sd3);
  endtask

  task automatic run_gain_extremes();
    drain_results();
    write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 23'h7F_FFFF);
    send_item(ppfe_pkg::CMD_STEP, 16'sh7FFF, 16'sh8000);
    send_item(ppfe_pkg::CMD_STEP, 16'sh8000, 16'sh7FFF);
    send_item(ppfe_pkg::CMD_STEP, 16'sd1, 16'sd0);
    send_item(ppfe_pkg::CMD_CLEAR, 16'sh8000, 16'sh8000);
    drain_results();
    write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 23'd1);
    send_item(ppfe_pkg::CMD_STEP, 16'sh8000, 16'sh7FFF);
    send_item(ppfe_pkg::CMD_STEP, 16'sh7FFF, 16'sh8000);
    send_item(ppfe_pkg::CMD_STEP, 16'sd0, -16'sd1);
    send_item(ppfe_pkg::CMD_STEP, 16'sd0, 16'sd0);
    send_item(ppfe_pkg::CMD_CLEAR, 16'sd0, 16'sd0);
  endtask

  // With the clamp off, the integral is driven up, then after a clear driven down.
  task automatic run_unclamped_integral();
    drain_results();
    write_all(32'd0, 32'd1, 32'd0, 23'd0);
    quiet = 1'b1;
    repeat (OPEN_STEPS) send_item(ppfe_pkg::CMD_STEP, 16'sh7FFF, 16'sh8000);
    send_item(ppfe_pkg::CMD_CLEAR, 16'sd0, 16'sd0);
    repeat (OPEN_STEPS) send_item(ppfe_pkg::CMD_STEP, 16'sh8000, 16'sh7FFF);
    send_item(ppfe_pkg::CMD_CLEAR, 16'sd0, 16'sd0);
    quiet = 1'b0;
  endtask

  task automatic random_step();
    ppfe_pkg::cmd_t cmd;
    logic signed [ppfe_pkg::MEAS_W-1:0] tgt;
    logic signed [ppfe_pkg::MEAS_W-1:0] meas;
    cmd = ($urandom_range(0, 15) == 0) ? ppfe_pkg::CMD_CLEAR : ppfe_pkg::CMD_STEP;
    tgt = pick_sample();
    // Half of the items stay close to the setpoint so the integral can settle.
    if ($urandom_range(0, 1) == 1) begin
      meas = tgt + ppfe_pkg::MEAS_W'($urandom_range(0, 64)) - 16'sd32;
    end else begin
      meas = pick_sample();
    end
    send_item(cmd, meas, tgt);
  endtask

  task automatic run_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        1: write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 23'h7F_FFFF);
        2: write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 23'd0);
        default: write_all(pick_gain(), pick_gain(), pick_gain(), pick_limit());
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) begin
          quiet = ($urandom_range(0, 3) == 0);
        end
        if (ph == 3 && n == 130) begin
          drain_results();
        end
        random_step();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = ppfe_pkg::CFG_KP_GAIN;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_command = ppfe_pkg::CMD_STEP;
    in_measured = '0;
    in_target = '0;
    out_stall = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_default_gain_steps();
    run_gain_extremes();
    run_unclamped_integral();
    run_random_phases();

    drain_results();
    if (mismatch_count == 0 && pending_drives.size() == 0) begin
      $display("positional_pid_filtered_error test passed");
    end else begin
      $display("positional_pid_filtered_error test failed");
    end
    $finish;
  end

endmodule
